// ----- sv/acr_pkg.sv -----
// Shared widths, bundle types and limits for the arc centre block.
package acr_pkg;
   localparam int CoordW   = 24;
   localparam int DiffW    = 25;
   localparam int DdW      = 50;
   localparam int NumW     = 49;
   localparam int QuotW    = 82;
   localparam int DivRemW  = 50;
   localparam int RootW    = 42;
   localparam int SqRemW   = 43;
   localparam int TLoW     = 21;
   localparam int ProdW    = 47;
   localparam int AccW     = 48;
   localparam int CenterW  = 25;
   localparam int QueueAw  = 2;

   typedef struct packed {
      logic                    ok;
      logic                    neg;
      logic signed [DiffW-1:0] sum_x;
      logic signed [DiffW-1:0] sum_y;
      logic signed [DiffW-1:0] dx;
      logic signed [DiffW-1:0] dy;
   } ctx_type;

   typedef struct packed {
      ctx_type         ctx;
      logic [NumW-1:0] n;
      logic [DdW-1:0]  d;
   } job_type;
endpackage

// ----- sv/arc_center_from_radius_top.sv -----
// Top level of the arc centre finder: front end, job queue and back end.
//
//  channel  dir  beat contents
//  req_     in   start, end, radius (tdata), clockwise (tuser)
//  rsp_     out  centre x, y (tdata), centre found (tuser)
//
// One beat a cycle sustained in both directions while rsp_ is not stalled; a req_
// beat reaches rsp_ through the 82-stage divider (one quotient bit a stage)
// and the 42-stage root.
// Reset is synchronous and clears only valid bits and the queue pointers and count.
// A stalled rsp_ freezes the back end; the four-entry queue lets the front
// end keep taking beats until it fills, then req_tready drops.
module arc_center_from_radius_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // start_x[23:0], start_y[47:24], end_x[71:48], end_y[95:72], radius[119:96]
   input  logic [119:0] req_tdata,
   // clockwise[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // center_x[24:0], center_y[49:25], zero pad[55:50]
   output logic [55:0]  rsp_tdata,
   // valid_res[0]
   output logic         rsp_tuser
);
   import acr_pkg::*;

   job_type                   front_job, head_job;
   logic                      push, full, empty, back_ready;
   logic signed [CenterW-1:0] cx, cy;

   acr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_data  (req_tdata),
      .in_cw    (req_tuser),
      .push     (push),
      .full     (full),
      .job      (front_job)
   );

   acr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (front_job),
      .full     (full),
      .pop      (back_ready),
      .empty    (empty),
      .head_job (head_job)
   );

   acr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!empty),
      .in_ready  (back_ready),
      .in_job    (head_job),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_cx    (cx),
      .out_cy    (cy),
      .out_ok    (rsp_tuser)
   );

   assign rsp_tdata = {6'b0, cy, cx};
endmodule

// ----- sv/acr_front.sv -----
// Front end: chord, squares and the radius check, one beat per cycle while the queue is not full.
module acr_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic [5*acr_pkg::CoordW-1:0]           in_data,
   input  logic                                  in_cw,
   output logic                                  push,
   input  logic                                  full,
   output acr_pkg::job_type                      job
);
   import acr_pkg::*;

   logic signed [CoordW-1:0] sx, sy, ex, ey, rr;
   logic                     en;

   logic                     s1_valid_ff, s1_valid_in;
   ctx_type                  s1_ctx_ff, s1_ctx_in;
   logic [CoordW-1:0]        s1_rmag_ff, s1_rmag_in;

   logic                     s2_valid_ff;
   ctx_type                  s2_ctx_ff;
   logic [DdW-1:0]           s2_dx2_ff, s2_dx2_in, s2_dy2_ff, s2_dy2_in;
   logic [2*CoordW-1:0]      s2_r2_ff, s2_r2_in;
   logic signed [DdW-1:0]    dx_sq, dy_sq;

   logic [DdW-1:0]           dd, r4;
   logic                     ok;

   assign sx = in_data[CoordW-1:0];
   assign sy = in_data[2*CoordW-1:CoordW];
   assign ex = in_data[3*CoordW-1:2*CoordW];
   assign ey = in_data[4*CoordW-1:3*CoordW];
   assign rr = in_data[5*CoordW-1:4*CoordW];

   assign en       = !s2_valid_ff || !full;
   assign in_ready = en;
   assign push     = s2_valid_ff && !full;

   always_comb begin
      s1_valid_in     = in_valid;
      s1_ctx_in.ok    = 1'b0;
      s1_ctx_in.neg   = in_cw ^ rr[CoordW-1];
      s1_ctx_in.sum_x = DiffW'(sx) + DiffW'(ex);
      s1_ctx_in.sum_y = DiffW'(sy) + DiffW'(ey);
      s1_ctx_in.dx    = DiffW'(ex) - DiffW'(sx);
      s1_ctx_in.dy    = DiffW'(ey) - DiffW'(sy);
      s1_rmag_in      = rr[CoordW-1] ? (~rr + CoordW'(1)) : rr;
   end

   assign dx_sq     = s1_ctx_ff.dx * s1_ctx_ff.dx;
   assign dy_sq     = s1_ctx_ff.dy * s1_ctx_ff.dy;
   assign s2_dx2_in = dx_sq;
   assign s2_dy2_in = dy_sq;
   assign s2_r2_in  = s1_rmag_ff * s1_rmag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ctx_ff  <= s1_ctx_in;
         s1_rmag_ff <= s1_rmag_in;
         s2_ctx_ff  <= s1_ctx_ff;
         s2_dx2_ff  <= s2_dx2_in;
         s2_dy2_ff  <= s2_dy2_in;
         s2_r2_ff   <= s2_r2_in;
      end
   end

   // zero chord or radius short of half the chord: no centre
   assign dd = s2_dx2_ff + s2_dy2_ff;
   assign r4 = {s2_r2_ff, 2'b00};
   assign ok = (dd != '0) && (r4 >= dd);

   always_comb begin
      job        = '0;
      job.ctx    = s2_ctx_ff;
      job.ctx.ok = ok;
      job.d      = dd;
      job.n      = ok ? NumW'(r4 - dd) : '0;
   end
endmodule

// ----- sv/acr_queue.sv -----
// Short queue of classified jobs between front and back.
module acr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  acr_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output acr_pkg::job_type  head_job
);
   import acr_pkg::*;

   localparam int Depth = 1 << QueueAw;

   job_type            mem_ff [0:Depth-1];
   logic [QueueAw-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QueueAw:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full     = (cnt_ff == (QueueAw+1)'(Depth));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + QueueAw'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + QueueAw'(1) : rd_ff;
      cnt_in = cnt_ff + (QueueAw+1)'(do_push) - (QueueAw+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end
endmodule

// ----- sv/acr_back.sv -----
// Back end: pipelined ratio divider, square root, offset multiply and rounding.
module acr_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  acr_pkg::job_type                    in_job,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [acr_pkg::CenterW-1:0]  out_cx,
   output logic signed [acr_pkg::CenterW-1:0]  out_cy,
   output logic                                out_ok
);
   import acr_pkg::*;

   localparam logic [AccW-1:0] Half    = AccW'(1) << 16;
   localparam logic [AccW-1:0] MagMax  = AccW'((1 << (CenterW-1)) - 1);
   localparam logic [AccW-1:0] MagMinN = AccW'(1 << (CenterW-1));

   logic en;

   // divider: quotient bits shift into the low end of the dividend word
   logic                dv_valid_ff [0:QuotW];
   ctx_type             dv_ctx_ff   [0:QuotW];
   logic [DivRemW-1:0]  dv_rem_ff   [0:QuotW];
   logic [QuotW-1:0]    dv_num_ff   [0:QuotW];
   logic [DdW-1:0]      dv_d_ff     [0:QuotW];

   // root: two radicand bits a stage
   logic                sq_valid_ff [1:RootW];
   ctx_type             sq_ctx_ff   [1:RootW];
   logic [SqRemW-1:0]   sq_rem_ff   [1:RootW];
   logic [RootW-1:0]    sq_root_ff  [1:RootW];
   logic [QuotW-1:0]    sq_rad_ff   [1:RootW];

   logic                       m1_valid_ff;
   ctx_type                    m1_ctx_ff;
   logic signed [ProdW-1:0]    m1_xl_ff, m1_xh_ff, m1_yl_ff, m1_yh_ff;
   logic signed [ProdW-1:0]    m1_xl_in, m1_xh_in, m1_yl_in, m1_yh_in;
   logic signed [TLoW:0]       t_lo, t_hi;

   logic                       m2_valid_ff;
   logic                       m2_ok_ff;
   logic signed [AccW-1:0]     m2_nx_ff, m2_ny_ff, m2_nx_in, m2_ny_in;
   logic signed [AccW-1:0]     dxt, dyt, base_x, base_y;

   logic                       out_valid_ff;
   logic                       out_ok_ff;
   logic signed [CenterW-1:0]  out_cx_ff, out_cy_ff, out_cx_in, out_cy_in;

   function automatic logic signed [CenterW-1:0] round17(input logic signed [AccW-1:0] v);
      logic [AccW-1:0] mag;
      logic [AccW-1:0] q;
      logic [CenterW-1:0] res;
      mag = v[AccW-1] ? (~v + AccW'(1)) : v;
      q   = (mag + Half) >> 17;
      if (!v[AccW-1]) begin
         res = (q > MagMax) ? CenterW'(MagMax) : CenterW'(q);
      end else begin
         res = (q > MagMinN) ? CenterW'(~MagMinN + AccW'(1))
                             : CenterW'(~q + AccW'(1));
      end
      return res;
   endfunction

   assign en       = !out_valid_ff || out_ready;
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (en) begin
         dv_valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ctx_ff[0] <= in_job.ctx;
         dv_rem_ff[0] <= '0;
         dv_num_ff[0] <= {1'b0, in_job.n, 32'b0};
         dv_d_ff[0]   <= in_job.d;
      end
   end

   for (genvar i = 0; i < QuotW; i++) begin : g_div
      logic [DivRemW:0] trial;
      logic             ge;
      assign trial = {dv_rem_ff[i], dv_num_ff[i][QuotW-1]};
      assign ge    = trial >= {1'b0, dv_d_ff[i]};
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[i+1] <= dv_valid_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dv_ctx_ff[i+1] <= dv_ctx_ff[i];
            dv_d_ff[i+1]   <= dv_d_ff[i];
            dv_rem_ff[i+1] <= ge ? DivRemW'(trial - {1'b0, dv_d_ff[i]})
                                 : DivRemW'(trial);
            dv_num_ff[i+1] <= {dv_num_ff[i][QuotW-2:0], ge};
         end
      end
   end

   for (genvar j = 0; j < RootW; j++) begin : g_root
      logic                valid_w;
      ctx_type             ctx_w;
      logic [SqRemW-1:0]   rem_w;
      logic [RootW-1:0]    root_w;
      logic [QuotW-1:0]    rad_w;
      logic [1:0]          pair_w;
      logic [QuotW-1:0]    rad_nx;
      logic [SqRemW+1:0]   cur, trial;
      logic                ge;
      if (j == 0) begin : g_first
         // 41 radicand pairs in 42 stages: the first stage takes a zero pair
         assign valid_w = dv_valid_ff[QuotW];
         assign ctx_w   = dv_ctx_ff[QuotW];
         assign rem_w   = '0;
         assign root_w  = '0;
         assign rad_w   = dv_num_ff[QuotW];
         assign pair_w  = 2'b00;
         assign rad_nx  = rad_w;
      end else begin : g_next
         assign valid_w = sq_valid_ff[j];
         assign ctx_w   = sq_ctx_ff[j];
         assign rem_w   = sq_rem_ff[j];
         assign root_w  = sq_root_ff[j];
         assign rad_w   = sq_rad_ff[j];
         assign pair_w  = rad_w[QuotW-1:QuotW-2];
         assign rad_nx  = {rad_w[QuotW-3:0], 2'b00};
      end
      assign cur   = {rem_w, pair_w};
      assign trial = (SqRemW+2)'({root_w, 2'b01});
      assign ge    = cur >= trial;
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[j+1] <= 1'b0;
         end else if (en) begin
            sq_valid_ff[j+1] <= valid_w;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ctx_ff[j+1]  <= ctx_w;
            sq_rem_ff[j+1]  <= ge ? SqRemW'(cur - trial) : SqRemW'(cur);
            sq_root_ff[j+1] <= {root_w[RootW-2:0], ge};
            sq_rad_ff[j+1]  <= rad_nx;
         end
      end
   end

   // t split in halves so each product stays narrow
   assign t_lo     = {1'b0, sq_root_ff[RootW][TLoW-1:0]};
   assign t_hi     = {1'b0, sq_root_ff[RootW][RootW-1:TLoW]};
   assign m1_xl_in = sq_ctx_ff[RootW].dx * t_lo;
   assign m1_xh_in = sq_ctx_ff[RootW].dx * t_hi;
   assign m1_yl_in = sq_ctx_ff[RootW].dy * t_lo;
   assign m1_yh_in = sq_ctx_ff[RootW].dy * t_hi;

   assign dxt    = (AccW'(m1_xh_ff) <<< TLoW) + AccW'(m1_xl_ff);
   assign dyt    = (AccW'(m1_yh_ff) <<< TLoW) + AccW'(m1_yl_ff);
   assign base_x = AccW'(m1_ctx_ff.sum_x) <<< 16;
   assign base_y = AccW'(m1_ctx_ff.sum_y) <<< 16;

   always_comb begin
      if (m1_ctx_ff.neg) begin
         m2_nx_in = base_x + dyt;
         m2_ny_in = base_y - dxt;
      end else begin
         m2_nx_in = base_x - dyt;
         m2_ny_in = base_y + dxt;
      end
   end

   assign out_cx_in = m2_ok_ff ? round17(m2_nx_ff) : '0;
   assign out_cy_in = m2_ok_ff ? round17(m2_ny_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff  <= sq_valid_ff[RootW];
         m2_valid_ff  <= m1_valid_ff;
         out_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ctx_ff <= sq_ctx_ff[RootW];
         m1_xl_ff  <= m1_xl_in;
         m1_xh_ff  <= m1_xh_in;
         m1_yl_ff  <= m1_yl_in;
         m1_yh_ff  <= m1_yh_in;
         m2_ok_ff  <= m1_ctx_ff.ok;
         m2_nx_ff  <= m2_nx_in;
         m2_ny_ff  <= m2_ny_in;
         out_ok_ff <= m2_ok_ff;
         out_cx_ff <= out_cx_in;
         out_cy_ff <= out_cy_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_cx    = out_cx_ff;
   assign out_cy    = out_cy_ff;
   assign out_ok    = out_ok_ff;
endmodule
